// ===== hdl/svp_pkg.sv =====
// Shared types, character codes and character-class functions of the version parser.
`default_nettype none

package svp_pkg;

  localparam int unsigned NUM_W = 31;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;

  typedef logic [NUM_W-1:0] num_t;

  typedef struct packed {
    logic ok;
    num_t major;
    num_t minor;
    num_t patch;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_tag(input logic [7:0] c);
    return is_digit(c) ||
           ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
           (c == CH_DOT) || (c == CH_DASH) || (c == CH_UNDER);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/semver_string_parser.sv =====
// Top level of the version string parser: input register, parse core, result register.
//
// Usage: the string arrives one byte per request on the input channel
// (in_valid, in_stall, in_char_byte); a zero byte ends it. Each zero byte
// yields exactly one request on the result channel carrying valid_res and
// the major, minor and patch numbers (all three zero when the string is bad).
// Non-zero bytes yield no result.
//
// Throughput is one byte per cycle while in_stall is low. A byte is captured
// in the input register when it is accepted and is processed from there; a
// zero byte loads the result register as it is processed, and out_valid
// comes from that register.
//
// When the receiver stalls, the result waits in the output register and the
// block keeps taking and parsing the following non-zero bytes. Only a second
// zero byte has to wait; it then holds the input register and in_stall rises
// until the pending result is taken.
//
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to the start of a string.
`default_nettype none

module semver_string_parser (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_char_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_valid_res,
  output logic [svp_pkg::NUM_W-1:0] out_major_num,
  output logic [svp_pkg::NUM_W-1:0] out_minor_num,
  output logic [svp_pkg::NUM_W-1:0] out_patch_num
);
  import svp_pkg::*;

  logic [7:0] byte_r;
  logic       byte_vld_r, byte_vld_nxt;
  logic       out_vld_r, out_vld_nxt;
  result_t    out_res_r;
  result_t    res;
  logic       out_free;
  logic       consume;
  logic       is_end;

  // The held byte is consumed unless it is an end byte and the previous
  // result has not been taken yet.
  assign is_end   = (byte_r == CH_NUL);
  assign out_free = !out_vld_r || !out_stall;
  assign consume  = byte_vld_r && (!is_end || out_free);
  assign in_stall = byte_vld_r && !consume;

  svp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (consume),
    .ch      (byte_r),
    .res     (res)
  );

  always_comb begin
    byte_vld_nxt = byte_vld_r;
    if (in_valid && !in_stall) begin
      byte_vld_nxt = 1'b1;
    end else if (consume) begin
      byte_vld_nxt = 1'b0;
    end

    out_vld_nxt = out_vld_r;
    if (consume && is_end) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      byte_vld_r <= byte_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_char_byte;
    end
    if (consume && is_end) begin
      out_res_r <= res;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_valid_res = out_res_r.ok;
  assign out_major_num = out_res_r.major;
  assign out_minor_num = out_res_r.minor;
  assign out_patch_num = out_res_r.patch;

endmodule

`default_nettype wire

// ===== hdl/svp_parse.sv =====
// Per-character parse state machine with number accumulation and result forming.
`default_nettype none

module svp_parse (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_en,
  input  wire logic [7:0]       ch,
  output svp_pkg::result_t      res
);
  import svp_pkg::*;

  typedef enum logic [2:0] {
    PH_MAJOR = 3'd0,
    PH_MINOR = 3'd1,
    PH_PATCH = 3'd2,
    PH_PRE   = 3'd3,
    PH_BUILD = 3'd4
  } phase_t;

  typedef logic [NUM_W+3:0] wide_t;

  phase_t phase_r, phase_nxt;
  logic   digit_seen_r, digit_seen_nxt;
  logic   tag_nonempty_r, tag_nonempty_nxt;
  logic   failed_r, failed_nxt;
  num_t   major_r, major_nxt;
  num_t   minor_r, minor_nxt;
  num_t   acc_r, acc_nxt;

  wide_t  acc_wide;
  wide_t  acc_times10;
  logic   overflow;
  logic   ok;
  logic [3:0] dig;

  // acc * 10 + digit as two shifted copies plus the digit. For the digit
  // characters the low nibble is the digit value.
  assign dig         = ch[3:0];
  assign acc_wide    = {4'b0000, acc_r};
  assign acc_times10 = (acc_wide << 3) + (acc_wide << 1) + {{NUM_W{1'b0}}, dig};
  assign overflow    = |acc_times10[NUM_W+3:NUM_W];

  assign ok = !failed_r &&
              (((phase_r == PH_PATCH) && digit_seen_r) ||
               (((phase_r == PH_PRE) || (phase_r == PH_BUILD)) && tag_nonempty_r));

  assign res.ok    = ok;
  assign res.major = ok ? major_r : '0;
  assign res.minor = ok ? minor_r : '0;
  assign res.patch = ok ? acc_r   : '0;

  always_comb begin
    phase_nxt        = phase_r;
    digit_seen_nxt   = digit_seen_r;
    tag_nonempty_nxt = tag_nonempty_r;
    failed_nxt       = failed_r;
    major_nxt        = major_r;
    minor_nxt        = minor_r;
    acc_nxt          = acc_r;

    if (step_en) begin
      if (ch == CH_NUL) begin
        // End of string: the result is taken from the current state, then restart.
        phase_nxt        = PH_MAJOR;
        digit_seen_nxt   = 1'b0;
        tag_nonempty_nxt = 1'b0;
        failed_nxt       = 1'b0;
        major_nxt        = '0;
        minor_nxt        = '0;
        acc_nxt          = '0;
      end else if (!failed_r) begin
        case (phase_r)
          PH_MAJOR, PH_MINOR, PH_PATCH: begin
            if (is_digit(ch)) begin
              if (overflow) begin
                failed_nxt = 1'b1;
              end else begin
                acc_nxt        = acc_times10[NUM_W-1:0];
                digit_seen_nxt = 1'b1;
              end
            end else if ((phase_r != PH_PATCH) && (ch == CH_DOT) && digit_seen_r) begin
              if (phase_r == PH_MAJOR) begin
                major_nxt = acc_r;
                phase_nxt = PH_MINOR;
              end else begin
                minor_nxt = acc_r;
                phase_nxt = PH_PATCH;
              end
              acc_nxt        = '0;
              digit_seen_nxt = 1'b0;
            end else if ((phase_r == PH_PATCH) && (ch == CH_DASH) && digit_seen_r) begin
              phase_nxt        = PH_PRE;
              tag_nonempty_nxt = 1'b0;
            end else if ((phase_r == PH_PATCH) && (ch == CH_PLUS) && digit_seen_r) begin
              phase_nxt        = PH_BUILD;
              tag_nonempty_nxt = 1'b0;
            end else begin
              failed_nxt = 1'b1;
            end
          end
          PH_PRE: begin
            if (is_tag(ch)) begin
              tag_nonempty_nxt = 1'b1;
            end else if ((ch == CH_PLUS) && tag_nonempty_r) begin
              phase_nxt        = PH_BUILD;
              tag_nonempty_nxt = 1'b0;
            end else begin
              failed_nxt = 1'b1;
            end
          end
          PH_BUILD: begin
            if (is_tag(ch)) begin
              tag_nonempty_nxt = 1'b1;
            end else begin
              failed_nxt = 1'b1;
            end
          end
          default: begin
            failed_nxt = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_MAJOR;
      digit_seen_r   <= 1'b0;
      tag_nonempty_r <= 1'b0;
      failed_r       <= 1'b0;
      major_r        <= '0;
      minor_r        <= '0;
      acc_r          <= '0;
    end else begin
      phase_r        <= phase_nxt;
      digit_seen_r   <= digit_seen_nxt;
      tag_nonempty_r <= tag_nonempty_nxt;
      failed_r       <= failed_nxt;
      major_r        <= major_nxt;
      minor_r        <= minor_nxt;
      acc_r          <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/svp_check.sv =====
// Port-level checker for the version string parser, bound to the top level.
`default_nettype none

module svp_check (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_stall,
  input wire logic [7:0]                in_char_byte,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic                      out_valid_res,
  input wire logic [svp_pkg::NUM_W-1:0] out_major_num,
  input wire logic [svp_pkg::NUM_W-1:0] out_minor_num,
  input wire logic [svp_pkg::NUM_W-1:0] out_patch_num
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result request dropped while stalled");

  // A stalled input request stays offered with the same byte.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_char_byte))
    else $error("input request changed while stalled");

  // The input only backs up behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // A bad string reports all numbers as zero.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |->
      out_major_num == '0 && out_minor_num == '0 && out_patch_num == '0)
    else $error("invalid result carries non-zero numbers");

  // No result can be pending in the first cycle after reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule

bind semver_string_parser svp_check u_svp_check (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_char_byte  (in_char_byte),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_valid_res (out_valid_res),
  .out_major_num (out_major_num),
  .out_minor_num (out_minor_num),
  .out_patch_num (out_patch_num)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the version string parser: random and directed strings, checked.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import svp_pkg::*;

  // Parse position of the predictor. Codes above READ_BUILD never arise in a
  // correct parse, and a string that reached one would count as bad.
  typedef enum logic [2:0] {
    READ_MAJOR,
    READ_MINOR,
    READ_PATCH,
    READ_PRE,
    READ_BUILD
  } field_t;

  localparam int IDLE_LIMIT = 1000;  // cycles with no transfer before giving up
  localparam int TAIL_CYCLES = 8;    // settle time after the last result

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_valid_res;
  num_t       out_major_num;
  num_t       out_minor_num;
  num_t       out_patch_num;

  semver_string_parser u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char_byte  (in_char_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res),
    .out_major_num (out_major_num),
    .out_minor_num (out_minor_num),
    .out_patch_num (out_patch_num)
  );

  // The clock idles low and rises 2 ns into the run, giving a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state. It follows every accepted byte and, at each zero byte,
  // queues the version that the block must report for the string just ended.
  // ---------------------------------------------------------------------------
  field_t  cur_phase = READ_MAJOR;
  logic    got_digit = 1'b0;      // current number holds at least one digit
  logic    got_tag_char = 1'b0;   // current tag holds at least one byte
  logic    string_bad = 1'b0;     // an error was seen; sticky until the zero byte
  num_t    saved_major = '0;
  num_t    saved_minor = '0;
  num_t    cur_value = '0;        // number being read; keeps patch during tags

  result_t expected_versions[$];

  // Knobs for the two sides. The tests change them between phases.
  int max_gap = 0;      // longest idle gap of the sender; 0 keeps valid high
  int max_burst = 1;    // longest run of bytes between two gaps
  int stall_pct = 0;    // chance per cycle that the receiver starts a stall
  int max_stall = 1;    // longest stall of the receiver in cycles

  int burst_left = 0;
  int stall_left = 0;
  int bytes_sent = 0;
  int errors = 0;
  int idle_cycles = 0;

  logic [7:0] word_q[$];  // the string being sent, without its zero byte

  string tag_chars =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-_";
  string edge_numbers[4] = '{"2147483647", "2147483648", "4294967296", "21474836470"};

  function automatic logic is_dec_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_tag_char(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE], [CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z],
                     CH_DOT, CH_DASH, CH_UNDER};
  endfunction

  task automatic restart_parse();
    cur_phase = READ_MAJOR;
    got_digit = 1'b0;
    got_tag_char = 1'b0;
    string_bad = 1'b0;
    saved_major = '0;
    saved_minor = '0;
    cur_value = '0;
  endtask

  // Advances the predictor by one accepted byte. A zero byte closes the
  // string: the version is valid only when the parse ended inside the patch
  // number with a digit, or inside a tag that is not empty, and no error was
  // seen before. All numbers read as zero for a bad string.
  task automatic parse_char(input logic [7:0] c);
    logic [34:0] grown;
    result_t     res;
    if (c == CH_NUL) begin
      res.ok = !string_bad &&
               ((cur_phase == READ_PATCH && got_digit) ||
                ((cur_phase == READ_PRE || cur_phase == READ_BUILD) && got_tag_char));
      res.major = res.ok ? saved_major : '0;
      res.minor = res.ok ? saved_minor : '0;
      res.patch = res.ok ? cur_value : '0;
      expected_versions.push_back(res);
      restart_parse();
    end else if (!string_bad) begin
      if (cur_phase inside {READ_MAJOR, READ_MINOR, READ_PATCH} && is_dec_digit(c)) begin
        // A digit that would carry the number past 2^31 - 1 spoils the string.
        grown = 35'(cur_value) * 35'd10 + 35'(c - CH_ZERO);
        if (grown > 35'h7FFF_FFFF) begin
          string_bad = 1'b1;
        end else begin
          cur_value = grown[30:0];
          got_digit = 1'b1;
        end
      end else begin
        case (cur_phase)
          READ_MAJOR, READ_MINOR: begin
            if (c == CH_DOT && got_digit) begin
              if (cur_phase == READ_MAJOR) saved_major = cur_value;
              else saved_minor = cur_value;
              cur_value = '0;
              got_digit = 1'b0;
              cur_phase = (cur_phase == READ_MAJOR) ? READ_MINOR : READ_PATCH;
            end else begin
              string_bad = 1'b1;
            end
          end
          READ_PATCH: begin
            if (got_digit && c == CH_DASH) begin
              cur_phase = READ_PRE;
              got_tag_char = 1'b0;
            end else if (got_digit && c == CH_PLUS) begin
              cur_phase = READ_BUILD;
              got_tag_char = 1'b0;
            end else begin
              string_bad = 1'b1;
            end
          end
          READ_PRE: begin
            if (is_tag_char(c)) begin
              got_tag_char = 1'b1;
            end else if (c == CH_PLUS && got_tag_char) begin
              cur_phase = READ_BUILD;
              got_tag_char = 1'b0;
            end else begin
              string_bad = 1'b1;
            end
          end
          READ_BUILD: begin
            if (is_tag_char(c)) got_tag_char = 1'b1;
            else string_bad = 1'b1;
          end
          default: begin
            string_bad = 1'b1;
          end
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender. It is called at a rising edge and returns at the edge where the
  // byte was taken. Valid stays high from one byte to the next inside a
  // burst; between bursts it drops for a random gap. The predictor sees the
  // byte in the same step it is taken, well before its result can appear.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] c);
    int gap;
    if (max_gap > 0 && burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      burst_left = $urandom_range(1, max_burst);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_char_byte <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_char(c);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_word();
    foreach (word_q[i]) send_byte(word_q[i]);
    send_byte(CH_NUL);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) word_q.push_back(s[i]);
  endtask

  // Lowers valid and waits until every queued version has been reported.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_versions.size() > 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Random string builder. Most strings are well formed with random numbers
  // and tags, so that the parse reaches the tag states. One string in four
  // is such a string with one byte replaced, dropped or inserted, or its tail
  // cut off, and one string in ten is plain noise over the whole non-zero byte range.
  // ---------------------------------------------------------------------------
  task automatic push_number();
    case ($urandom_range(7))
      0: push_text(edge_numbers[$urandom_range(0, 3)]);
      1: repeat ($urandom_range(1, 11)) word_q.push_back(8'(CH_ZERO + $urandom_range(9)));
      2: begin
        repeat ($urandom_range(1, 4)) word_q.push_back(CH_ZERO);
        repeat ($urandom_range(1, 3)) word_q.push_back(8'(CH_ZERO + $urandom_range(9)));
      end
      default: repeat ($urandom_range(1, 3)) word_q.push_back(8'(CH_ZERO + $urandom_range(9)));
    endcase
  endtask

  task automatic push_tag();
    repeat ($urandom_range(1, 6)) word_q.push_back(tag_chars[$urandom_range(0, tag_chars.len() - 1)]);
  endtask

  task automatic gen_string();
    int kind;
    int pos;
    word_q.delete();
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(0, 8)) word_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      push_number();
      word_q.push_back(CH_DOT);
      push_number();
      word_q.push_back(CH_DOT);
      push_number();
      case ($urandom_range(3))
        0: ;
        1: begin
          word_q.push_back(CH_DASH);
          push_tag();
        end
        2: begin
          word_q.push_back(CH_PLUS);
          push_tag();
        end
        default: begin
          word_q.push_back(CH_DASH);
          push_tag();
          word_q.push_back(CH_PLUS);
          push_tag();
        end
      endcase
      if (kind >= 75) begin
        pos = $urandom_range(0, word_q.size() - 1);
        case ($urandom_range(3))
          0: word_q[pos] = 8'($urandom_range(1, 255));
          1: word_q.delete(pos);
          2: begin
            case ($urandom_range(4))
              0: word_q.insert(pos, CH_DOT);
              1: word_q.insert(pos, CH_DASH);
              2: word_q.insert(pos, CH_PLUS);
              3: word_q.insert(pos, CH_UNDER);
              default: word_q.insert(pos, 8'($urandom_range(1, 255)));
            endcase
          end
          default: while (word_q.size() > pos) void'(word_q.pop_back());
        endcase
      end
    end
  endtask

  task automatic run_random(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      gen_string();
      send_word();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver. Stalls come in runs of random length; with stall_pct at zero
  // the result channel never pushes back.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, max_stall - 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker. Values are sampled at the edge, before any update of
  // that edge lands, so the order of processes within the step does not
  // matter.
  result_t seen_version;
  result_t want_version;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_version = '{ok: out_valid_res, major: out_major_num,
                       minor: out_minor_num, patch: out_patch_num};
      if (expected_versions.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: ok=%0b %0d.%0d.%0d", $time,
                 seen_version.ok, seen_version.major, seen_version.minor,
                 seen_version.patch);
      end else begin
        want_version = expected_versions.pop_front();
        if (seen_version !== want_version) begin
          errors++;
          $display("%0t: mismatch: expected ok=%0b %0d.%0d.%0d, got ok=%0b %0d.%0d.%0d",
                   $time, want_version.ok, want_version.major, want_version.minor,
                   want_version.patch, seen_version.ok, seen_version.major,
                   seen_version.minor, seen_version.patch);
        end
      end
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked strings: field extremes, both tag kinds, leading zeros, the
  // empty string, empty numbers and tags, overflow, stray bytes, and an
  // error that must hold even when the rest of the string looks right.
  task automatic test_directed_strings();
    string cases[16] = '{
      "0.0.0", "2147483647.2147483647.2147483647", "2147483648.1.1",
      "007.08.09-rc.1+exp_sha-5", "1.2.3+Build.7", "", "1..3", ".1.2",
      "1.2.3-", "1.2.3-+b", "1.2.3+", "1.2.3-a+", "1.2.3+a+b", "1.2",
      "1.2.3.4", "99999999999.1.1"
    };
    foreach (cases[i]) begin
      word_q.delete();
      push_text(cases[i]);
      send_word();
    end
    // Bytes with the top bit set, inside a tag and inside a number.
    word_q.delete();
    push_text("1.2.3-x");
    word_q.push_back(8'hFF);
    send_word();
    word_q.delete();
    push_text("1.2");
    word_q.push_back(8'h80);
    push_text(".3");
    send_word();
  endtask

  // Back-to-back bytes and a receiver that never stalls.
  task automatic test_random_streaming();
    max_gap = 0;
    stall_pct = 0;
    run_random(200);
  endtask

  // Bursty sender against a lightly stalling receiver.
  task automatic test_random_bursty();
    max_gap = 6;
    max_burst = 12;
    stall_pct = 20;
    max_stall = 4;
    run_random(300);
  endtask

  // Long stalls, so that a second zero byte has to wait behind a pending
  // result while the parse of the next string goes on.
  task automatic test_random_backpressure();
    max_gap = 2;
    max_burst = 30;
    stall_pct = 40;
    max_stall = 20;
    run_random(250);
  endtask

  // The sender pauses until every result has been taken, then resumes.
  task automatic test_drain_pause();
    max_gap = 3;
    max_burst = 8;
    stall_pct = 25;
    max_stall = 8;
    repeat (6) begin
      repeat (3) begin
        gen_string();
        send_word();
      end
      wait_drain();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_strings();
    test_random_streaming();
    test_random_bursty();
    test_random_backpressure();
    test_drain_pause();
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
